// ===== hdl/fed_pkg.sv =====
package fed_pkg;

    localparam int unsigned DATA_W            = 16;
    localparam int unsigned GAIN_W            = 15;
    localparam int unsigned DEFAULT_MAX_DELAY = 32768;

    localparam logic [15:0]       RESET_DELAY_LENGTH  = 16'd4800;
    localparam logic [15:0]       RESET_WET_MIX       = 16'd16384;
    localparam logic [GAIN_W-1:0] RESET_FEEDBACK_GAIN = '0;

    // Unity in Q1.15
    localparam logic [15:0] UNITY = 16'd32768;

    typedef enum logic [1:0] {
        REG_DELAY_LENGTH  = 2'd0,
        REG_WET_MIX       = 2'd1,
        REG_FEEDBACK_GAIN = 2'd2
    } cfg_index_t;

    // Clamp an 18-bit signed sum to the 16-bit sample range.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [17:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/fed_store.sv =====
module fed_store #(
    parameter int unsigned DEPTH = fed_pkg::DEFAULT_MAX_DELAY,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [fed_pkg::DATA_W-1:0] rd_data,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [fed_pkg::DATA_W-1:0] wr_data
);

    // single write port, one registered read port; read-during-write gives old data
    logic signed [fed_pkg::DATA_W-1:0] mem [DEPTH];
    logic signed [fed_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/feedback_echo_delay.sv =====
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------
// sample_in | in        | sample_in_valid/_stall     | sample_in   (Q1.15, signed)
// sample_out| out       | sample_out_valid/_stall    | sample_out  (Q1.15, signed)
// cfg       | in        | cfg_valid/cfg_ready        | cfg_index, cfg_data
//
// One sample per cycle sustained while sample_out is not stalled; the result
// register loads from stage 2. The rate is set by the single read/write port pair
// of the delay memory: one read at accept, one write-back from stage 1.
// Reset and a delay_length write take effect at once: no clearing pass runs.
// A wrap flag masks slots not yet written since the last clear to zero.
// A stall on sample_out with a full result register freezes the whole pipe.
module feedback_echo_delay #(
    parameter int unsigned MAX_DELAY_SAMPLES = fed_pkg::DEFAULT_MAX_DELAY
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              sample_in_valid,
    output logic                              sample_in_stall,
    input  logic signed [fed_pkg::DATA_W-1:0] sample_in,

    output logic                              sample_out_valid,
    input  logic                              sample_out_stall,
    output logic signed [fed_pkg::DATA_W-1:0] sample_out,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    localparam int unsigned AW = (MAX_DELAY_SAMPLES > 1) ? $clog2(MAX_DELAY_SAMPLES) : 1;
    localparam logic [31:0] MAX_LEN  = 32'(MAX_DELAY_SAMPLES);
    localparam logic [AW-1:0] MAX_LAST = AW'(MAX_DELAY_SAMPLES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]                 delay_length_reg;
    logic [15:0]                 wet_mix_reg;
    logic [fed_pkg::GAIN_W-1:0]  feedback_gain_reg;
    logic                        cfg_write;
    logic                        clear_store;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign clear_store = cfg_write && (cfg_index == fed_pkg::REG_DELAY_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg  <= fed_pkg::RESET_DELAY_LENGTH;
            wet_mix_reg       <= fed_pkg::RESET_WET_MIX;
            feedback_gain_reg <= fed_pkg::RESET_FEEDBACK_GAIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fed_pkg::REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data;
                fed_pkg::REG_WET_MIX:       wet_mix_reg       <= cfg_data;
                fed_pkg::REG_FEEDBACK_GAIN: feedback_gain_reg <= cfg_data[fed_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Last valid position: length clamped to 1..MAX_DELAY_SAMPLES, minus one.
    logic [31:0]   len_m1;
    logic [AW-1:0] used_last;

    assign len_m1 = {16'd0, delay_length_reg} - 32'd1;

    always_comb
    begin
        if (delay_length_reg == 16'd0)
        begin
            used_last = '0;
        end
        else if ({16'd0, delay_length_reg} > MAX_LEN)
        begin
            used_last = MAX_LAST;
        end
        else
        begin
            used_last = len_m1[AW-1:0];
        end
    end

    // Wet mix clamped to unity, dry coefficient is its complement.
    logic [15:0] mix_eff;
    logic [15:0] dry_coef;

    assign mix_eff  = (wet_mix_reg > fed_pkg::UNITY) ? fed_pkg::UNITY : wet_mix_reg;
    assign dry_coef = fed_pkg::UNITY - mix_eff;

    // ------------------------------------------------------------------
    // Pipeline control: everything advances unless the result register
    // holds a transaction that the sink is stalling.
    // ------------------------------------------------------------------
    logic adv;
    logic in_accept;

    assign adv             = !sample_out_valid || !sample_out_stall;
    assign sample_in_stall = !adv;
    assign in_accept       = sample_in_valid && adv;

    // ------------------------------------------------------------------
    // Stage 0: write position and wrap flag; issue the memory read
    // ------------------------------------------------------------------
    logic [AW-1:0] pos_reg, pos_next;
    logic          filled_reg, filled_next;
    logic          pos_wrap;

    assign pos_wrap = (pos_reg == used_last);

    always_comb
    begin
        pos_next    = pos_reg;
        filled_next = filled_reg;
        if (clear_store)
        begin
            pos_next    = '0;
            filled_next = 1'b0;
        end
        else if (in_accept)
        begin
            pos_next = pos_wrap ? '0 : pos_reg + AW'(1);
            if (pos_wrap)
            begin
                filled_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            filled_reg <= filled_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: delayed sample arrives; feedback write-back and products
    // ------------------------------------------------------------------
    logic                              s1_valid_reg;
    logic [AW-1:0]                     s1_pos_reg;
    logic signed [fed_pkg::DATA_W-1:0] s1_x_reg;
    logic                              s1_empty_reg;  // slot not written since clear
    logic                              s1_fwd_reg;    // slot written by the item just ahead
    logic signed [fed_pkg::DATA_W-1:0] s1_fwd_data_reg;

    logic signed [fed_pkg::DATA_W-1:0] rd_data;
    logic signed [fed_pkg::DATA_W-1:0] s1_d;
    logic signed [31:0]                fb_prod;
    logic signed [17:0]                fb_sum;
    logic signed [fed_pkg::DATA_W-1:0] fb_data;
    logic                              s1_write;
    logic signed [32:0]                dry_prod;
    logic signed [32:0]                wet_prod;

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            s1_d = s1_fwd_data_reg;
        end
        else if (s1_empty_reg)
        begin
            s1_d = '0;
        end
        else
        begin
            s1_d = rd_data;
        end
    end

    // Products shifted right by 15 with floor, as an arithmetic shift does.
    assign fb_prod  = s1_d * $signed({1'b0, feedback_gain_reg});
    assign fb_sum   = 18'(s1_x_reg) + 18'($signed(fb_prod[31:15]));
    assign fb_data  = fed_pkg::sat16(fb_sum);
    assign s1_write = s1_valid_reg && adv;

    assign dry_prod = s1_x_reg * $signed({1'b0, dry_coef});
    assign wet_prod = s1_d * $signed({1'b0, mix_eff});

    fed_store #(
        .DEPTH(MAX_DELAY_SAMPLES)
    ) u_store (
        .clk    (clk),
        .rd_en  (in_accept),
        .rd_addr(pos_reg),
        .rd_data(rd_data),
        .wr_en  (s1_write),
        .wr_addr(s1_pos_reg),
        .wr_data(fb_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample_in_valid;
        end
    end

    // With a one-sample delay the next read hits the slot being written
    // this same edge; the memory returns old data, so bypass it.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pos_reg      <= pos_reg;
            s1_x_reg        <= sample_in;
            s1_empty_reg    <= !filled_reg;
            s1_fwd_reg      <= s1_valid_reg && (s1_pos_reg == pos_reg);
            s1_fwd_data_reg <= fb_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sum of dry and wet terms
    // ------------------------------------------------------------------
    logic               s2_valid_reg;
    logic signed [16:0] s2_dry_reg;
    logic signed [16:0] s2_wet_reg;
    logic signed [17:0] mix_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_write)
        begin
            s2_dry_reg <= dry_prod[31:15];
            s2_wet_reg <= wet_prod[31:15];
        end
    end

    assign mix_sum = 18'(s2_dry_reg) + 18'(s2_wet_reg);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                              out_valid_reg;
    logic signed [fed_pkg::DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_data_reg <= fed_pkg::sat16(mix_sum);
        end
    end

    assign sample_out_valid = out_valid_reg;
    assign sample_out       = out_data_reg;

`ifndef ASSERT_OFF
    // Write position never leaves the used part of the store.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= used_last)
        else $error("write position beyond delay length");

    // The bypass is only needed when the delay is a single sample.
    a_fwd_len: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (used_last == '0))
        else $error("bypass taken with delay longer than one");

    // A held result freezes the pipe: no write-back, no new read.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_out_valid && sample_out_stall) |-> (!s1_write && !in_accept))
        else $error("pipeline moved while result stalled");

    // Every accepted sample occupies stage one on the next cycle.
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted transaction lost before stage one");
`endif

endmodule

// ===== tb/echo_checker.sv =====
module echo_checker #(
    parameter int unsigned MAX_DELAY = fed_pkg::DEFAULT_MAX_DELAY
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              sample_in_valid,
    input  logic                              sample_in_stall,
    input  logic signed [fed_pkg::DATA_W-1:0] sample_in,

    input  logic                              sample_out_valid,
    input  logic                              sample_out_stall,
    input  logic signed [fed_pkg::DATA_W-1:0] sample_out,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,

    output int                                mismatches,
    output int                                waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [fed_pkg::DATA_W-1:0] echo_mem [MAX_DELAY];
    logic [15:0]                       delay_len;
    logic [15:0]                       wet;
    logic [fed_pkg::GAIN_W-1:0]        gain;
    int unsigned                       wpos;

    // one entry per accepted input sample, oldest first
    logic signed [fed_pkg::DATA_W-1:0] echo_expected [$];

    function automatic logic signed [fed_pkg::DATA_W-1:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[fed_pkg::DATA_W-1:0];
    endfunction

    function automatic void clear_store();
        for (int i = 0; i < MAX_DELAY; i++) begin
            echo_mem[i] = '0;
        end
        wpos = 0;
    endfunction

    // Read the oldest slot, write back dry plus scaled echo, advance the
    // position, and blend dry and delayed by the wet proportion.
    function automatic logic signed [fed_pkg::DATA_W-1:0] predict_echo(
        input logic signed [fed_pkg::DATA_W-1:0] dry
    );
        int unsigned span;
        int unsigned pos;
        int unsigned mix;
        longint      delayed;
        longint      blend;
        span = delay_len;
        if (span < 1) begin
            span = 1;
        end
        if (span > MAX_DELAY) begin
            span = MAX_DELAY;
        end
        mix = (wet > fed_pkg::UNITY) ? fed_pkg::UNITY : wet;
        pos = (wpos >= span) ? 0 : wpos;
        delayed = echo_mem[pos];
        // >>> on a signed longint floors, as the hardware truncation does
        echo_mem[pos] = clamp16(longint'(dry) + ((delayed * longint'(gain)) >>> 15));
        pos++;
        if (pos >= span) begin
            pos = 0;
        end
        wpos = pos;
        blend = ((longint'(dry) * (longint'(fed_pkg::UNITY) - longint'(mix))) >>> 15)
              + ((delayed * longint'(mix)) >>> 15);
        return clamp16(blend);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [fed_pkg::DATA_W-1:0] want;
        if (!rst_n)
        begin
            clear_store();
            delay_len = fed_pkg::RESET_DELAY_LENGTH;
            wet       = fed_pkg::RESET_WET_MIX;
            gain      = fed_pkg::RESET_FEEDBACK_GAIN;
            echo_expected.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fed_pkg::REG_DELAY_LENGTH:
                    begin
                        delay_len = cfg_data;
                        clear_store();
                    end
                    fed_pkg::REG_WET_MIX:       wet  = cfg_data;
                    fed_pkg::REG_FEEDBACK_GAIN: gain = cfg_data[fed_pkg::GAIN_W-1:0];
                    default:                    ;
                endcase
            end
            if (sample_out_valid && !sample_out_stall)
            begin
                if (echo_expected.size() == 0)
                begin
                    $error("sample_out: expected nothing, actual %0d", sample_out);
                    mismatches++;
                end
                else
                begin
                    want = echo_expected.pop_front();
                    if (sample_out !== want)
                    begin
                        $error("sample_out: expected %0d, actual %0d", want, sample_out);
                        mismatches++;
                    end
                end
            end
            if (sample_in_valid && !sample_in_stall)
            begin
                echo_expected.push_back(predict_echo(sample_in));
            end
        end
        waiting = echo_expected.size();
    end

endmodule

// ===== tb/feedback_echo_delay_test.sv =====
// Echo delay test bench. Stimulus and verdict live here; prediction and
// comparison live in echo_checker, which sits beside the DUT and watches
// the three channels.
module feedback_echo_delay_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 is decoded by nobody; a write there must change nothing.
    localparam logic [1:0] REG_SPARE   = 2'd3;
    // The limit keeps a wide margin over the slowest run.
    localparam int         CYCLE_LIMIT = 600_000;
    // Long phase: several wraps of a mid-size delay.
    localparam int         LONG_ITEMS  = 370;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                              sample_in_valid  = 1'b0;
    logic                              sample_in_stall;
    logic signed [fed_pkg::DATA_W-1:0] sample_in        = '0;

    logic                              sample_out_valid;
    logic                              sample_out_stall = 1'b0;
    logic signed [fed_pkg::DATA_W-1:0] sample_out;

    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = '0;
    logic [15:0]              cfg_data  = '0;

    int   mismatches;
    int   waiting;
    int   cycle_count = 0;

    // When set, neither side idles: back-to-back transactions at full rate.
    logic steady = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    feedback_echo_delay dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_in_valid  (sample_in_valid),
        .sample_in_stall  (sample_in_stall),
        .sample_in        (sample_in),
        .sample_out_valid (sample_out_valid),
        .sample_out_stall (sample_out_stall),
        .sample_out       (sample_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    echo_checker echo_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_in_valid  (sample_in_valid),
        .sample_in_stall  (sample_in_stall),
        .sample_in        (sample_in),
        .sample_out_valid (sample_out_valid),
        .sample_out_stall (sample_out_stall),
        .sample_out       (sample_out),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatches       (mismatches),
        .waiting          (waiting)
    );

    // Output back-pressure: roughly one cycle in five stalled, none while
    // steady is set. A fresh draw every edge puts stalls on every pipe phase.
    always @(posedge clk)
    begin
        sample_out_stall <= !steady && ($urandom_range(0, 99) < 21);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly full-range noise, with rail values and small signals mixed in
    // so saturation and floor truncation near zero both get hit.
    function automatic logic signed [fed_pkg::DATA_W-1:0] pick_sample();
        logic [15:0] r;
        r = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return {{8{r[7]}}, r[7:0]};
            default: return r;
        endcase
    endfunction

    // Mostly short delays so the echo path wraps within a phase; zero and
    // above-max values check the clamps.
    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'h8000;
            3:       return 16'($urandom_range(32769, 65535));
            4:       return 16'($urandom_range(100, 4000));
            default: return 16'($urandom_range(2, 48));
        endcase
    endfunction

    function automatic logic [15:0] pick_mix();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return fed_pkg::UNITY;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Full 16-bit data: the top bit must be dropped by the 15-bit register.
    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One config transaction. cfg_valid is left high so back-to-back writes
    // never drop and re-raise it in one step; callers lower it afterwards.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // One sample transaction, preceded by a random number of idle cycles.
    // valid stays high on return so the next sample can follow directly.
    task automatic send_sample(input logic signed [fed_pkg::DATA_W-1:0] s);
        while (!steady && ($urandom_range(0, 99) < 21))
        begin
            sample_in_valid <= 1'b0;
            @(posedge clk);
        end
        sample_in_valid <= 1'b1;
        sample_in       <= s;
        do @(posedge clk); while (sample_in_stall);
    endtask

    // Quiet the input, wait until every predicted sample has come out, then
    // let the pipe idle before any config write.
    task automatic settle();
        sample_in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 4800-sample delay, half wet, no feedback.
        send_sample('0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        settle();

        // One-sample delay, fully wet, max feedback: rails drive the write
        // back into saturation in both directions.
        write_reg(fed_pkg::REG_DELAY_LENGTH, 16'd1);
        write_reg(fed_pkg::REG_WET_MIX, fed_pkg::UNITY);
        write_reg(fed_pkg::REG_FEEDBACK_GAIN, 16'h7fff);
        cfg_valid <= 1'b0;
        repeat (4) send_sample(16'sh7fff);
        repeat (4) send_sample(16'sh8000);
        settle();

        // Zero delay acts as one; fully dry; gain data with the top bit set;
        // a write to the undecoded index in between.
        write_reg(fed_pkg::REG_DELAY_LENGTH, '0);
        write_reg(fed_pkg::REG_WET_MIX, '0);
        write_reg(fed_pkg::REG_FEEDBACK_GAIN, 16'hffff);
        write_reg(REG_SPARE, 16'hffff);
        cfg_valid <= 1'b0;
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        settle();

        // Mix above unity is clamped to fully wet.
        write_reg(fed_pkg::REG_DELAY_LENGTH, 16'd2);
        write_reg(fed_pkg::REG_WET_MIX, 16'hffff);
        cfg_valid <= 1'b0;
        send_sample(16'sh4000);
        send_sample(16'shc000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        settle();

        // Random phases. Most rewrite the delay (clearing the store); the
        // rest keep the echo history across the new mix and gain.
        for (int ph = 0; ph < 24; ph++)
        begin
            steady = (ph == 3) || (ph == 4);
            if ($urandom_range(0, 9) < 7)
            begin
                write_reg(fed_pkg::REG_DELAY_LENGTH, pick_delay());
            end
            write_reg(fed_pkg::REG_WET_MIX, pick_mix());
            write_reg(fed_pkg::REG_FEEDBACK_GAIN, pick_gain());
            if (ph == 7)
            begin
                write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
            end
            cfg_valid <= 1'b0;
            repeat (40) send_sample(pick_sample());
            settle();
        end

        // Mid-size delay with strong feedback: several wraps so the
        // first-pass masking and the echo buildup both get exercised.
        // Full rate at the start.
        write_reg(fed_pkg::REG_DELAY_LENGTH, 16'd120);
        write_reg(fed_pkg::REG_WET_MIX, 16'($urandom_range(0, 32768)));
        write_reg(fed_pkg::REG_FEEDBACK_GAIN, 16'd20000);
        cfg_valid <= 1'b0;
        steady = 1'b1;
        for (int i = 0; i < LONG_ITEMS; i++)
        begin
            if (i == 200)
            begin
                steady = 1'b0;
            end
            send_sample(pick_sample());
        end
        settle();

        if (mismatches == 0 && waiting == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
